// File: rtl/pdr_pkg.sv
`default_nettype none

package pdr_pkg;

  // Default coordinate width: signed fixed point, Q11.12.
  localparam int unsigned CoordWidthDef = 24;

  // Configuration register index.
  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_REF_X = 2'd0,
    REG_REF_Y = 2'd1,
    REG_REF_Z = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: rtl/point_distance_to_reference.sv
// Euclidean distance from each point to a reference point.
//
// Points arrive on the in channel (in_valid_i / in_ready_o) with signed
// fixed-point coordinates; each item gives one distance on the out channel
// (out_valid_o / out_ready_i), unsigned with the same fraction bits, the
// square root of the summed squares rounded down.
// The reference point is written through the cfg channel, index 0 to 2 for
// x, y and z; other indices are ignored. The port always takes a write.
// The pipeline has three front stages (difference, square, sum), then one
// cell per root bit, each cell settling one bit with one compare and
// subtract. One item enters per cycle while in_ready_o is high.
// Every stage holds its item while the next is full, so when the receiver
// stalls the row fills up and in_ready_o falls only once no stage is free;
// empty stages keep taking items meanwhile.
// Reset empties the pipeline and sets the reference point to the origin.
`default_nettype none

module point_distance_to_reference import pdr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [COORD_WIDTH-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [COORD_WIDTH-1:0] point_x_i,
  input  wire logic [COORD_WIDTH-1:0] point_y_i,
  input  wire logic [COORD_WIDTH-1:0] point_z_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [COORD_WIDTH:0]        distance_o
);

  localparam int unsigned SW     = 2 * COORD_WIDTH + 2;
  localparam int unsigned RW     = COORD_WIDTH + 1;
  localparam int unsigned NCELLS = COORD_WIDTH + 1;

  logic [COORD_WIDTH-1:0] ref_x_q, ref_y_q, ref_z_q;

  logic [SW-1:0] rem_s   [NCELLS+1];
  logic [RW-1:0] root_s  [NCELLS+1];
  logic          valid_s [NCELLS+1];
  logic          ready_s [NCELLS+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= '0;
      ref_y_q <= '0;
      ref_z_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_REF_X: ref_x_q <= cfg_data_i;
        REG_REF_Y: ref_y_q <= cfg_data_i;
        REG_REF_Z: ref_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pdr_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .ref_x_i     (ref_x_q),
    .ref_y_i     (ref_y_q),
    .ref_z_i     (ref_z_q),
    .out_valid_o (valid_s[0]),
    .out_ready_i (ready_s[0]),
    .sum_o       (rem_s[0])
  );

  assign root_s[0] = '0;

  // Cell i settles root bit COORD_WIDTH - i, most significant first.
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    pdr_sqrt_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .BIT         (COORD_WIDTH - i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_s[i]),
      .in_ready_o  (ready_s[i]),
      .rem_i       (rem_s[i]),
      .root_i      (root_s[i]),
      .out_valid_o (valid_s[i+1]),
      .out_ready_i (ready_s[i+1]),
      .rem_o       (rem_s[i+1]),
      .root_o      (root_s[i+1])
    );
  end

  assign ready_s[NCELLS] = out_ready_i;
  assign out_valid_o     = valid_s[NCELLS];
  assign distance_o      = root_s[NCELLS];

endmodule

`default_nettype wire

// File: rtl/pdr_front.sv
`default_nettype none

module pdr_front import pdr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [COORD_WIDTH-1:0]   point_x_i,
  input  wire logic [COORD_WIDTH-1:0]   point_y_i,
  input  wire logic [COORD_WIDTH-1:0]   point_z_i,
  input  wire logic [COORD_WIDTH-1:0]   ref_x_i,
  input  wire logic [COORD_WIDTH-1:0]   ref_y_i,
  input  wire logic [COORD_WIDTH-1:0]   ref_z_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [2*COORD_WIDTH+1:0]      sum_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = 2 * COORD_WIDTH + 2;

  logic [2:0] valid_q;
  logic [3:0] rdy;

  logic signed [W:0] diff_x, diff_y, diff_z;
  logic [W-1:0]      mag_x_d, mag_y_d, mag_z_d;
  logic [W-1:0]      mag_x_q, mag_y_q, mag_z_q;
  logic [2*W-1:0]    sq_x_d, sq_y_d, sq_z_d;
  logic [2*W-1:0]    sq_x_q, sq_y_q, sq_z_q;
  logic [SW-1:0]     sum_d, sum_q;

  // A stage takes a new item when it is empty or its item moves on.
  assign rdy[3] = out_ready_i;
  assign rdy[2] = !valid_q[2] || rdy[3];
  assign rdy[1] = !valid_q[1] || rdy[2];
  assign rdy[0] = !valid_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  assign diff_x = $signed({point_x_i[W-1], point_x_i}) - $signed({ref_x_i[W-1], ref_x_i});
  assign diff_y = $signed({point_y_i[W-1], point_y_i}) - $signed({ref_y_i[W-1], ref_y_i});
  assign diff_z = $signed({point_z_i[W-1], point_z_i}) - $signed({ref_z_i[W-1], ref_z_i});

  // The magnitude of a difference never exceeds 2^W - 1, so W bits hold it.
  always_comb begin
    mag_x_d = diff_x[W] ? W'(-diff_x) : diff_x[W-1:0];
    mag_y_d = diff_y[W] ? W'(-diff_y) : diff_y[W-1:0];
    mag_z_d = diff_z[W] ? W'(-diff_z) : diff_z[W-1:0];
  end

  assign sq_x_d = mag_x_q * mag_x_q;
  assign sq_y_d = mag_y_q * mag_y_q;
  assign sq_z_d = mag_z_q * mag_z_q;

  assign sum_d = SW'(sq_x_q) + SW'(sq_y_q) + SW'(sq_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy[0]) begin
      mag_x_q <= mag_x_d;
      mag_y_q <= mag_y_d;
      mag_z_q <= mag_z_d;
    end
    if (valid_q[0] && rdy[1]) begin
      sq_x_q <= sq_x_d;
      sq_y_q <= sq_y_d;
      sq_z_q <= sq_z_d;
    end
    if (valid_q[1] && rdy[2]) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = valid_q[2];
  assign sum_o       = sum_q;

endmodule

`default_nettype wire

// File: rtl/pdr_sqrt_cell.sv
`default_nettype none

module pdr_sqrt_cell import pdr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned BIT         = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [2*COORD_WIDTH+1:0] rem_i,
  input  wire logic [COORD_WIDTH:0]     root_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [2*COORD_WIDTH+1:0]      rem_o,
  output logic [COORD_WIDTH:0]          root_o
);

  localparam int unsigned SW = 2 * COORD_WIDTH + 2;
  localparam int unsigned RW = COORD_WIDTH + 1;

  logic          valid_q;
  logic [SW-1:0] trial;
  logic          take;
  logic [SW-1:0] rem_d, rem_q;
  logic [RW-1:0] root_d, root_q;

  // The remainder holds the radicand minus root squared. Setting this bit
  // adds root * 2^(BIT+1) + 2^(2*BIT) to the square; all lower root bits
  // are still clear, so the two terms do not overlap.
  assign trial = (SW'(root_i) << (BIT + 1)) | (SW'(1) << (2 * BIT));
  assign take  = rem_i >= trial;

  always_comb begin
    rem_d  = take ? rem_i - trial : rem_i;
    root_d = root_i | (RW'(take) << BIT);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire
